// ===== hw/rtl/spe_pkg.sv =====
// spe_pkg: shared types and constants of the sprite particle engine.
// Command word between front and back, sprite word, mode and register codes.
// No dependencies.
package spe_pkg;

	// Item operation codes
	localparam logic OP_LOAD = 1'b0;
	localparam logic OP_TICK = 1'b1;

	// Weather modes
	localparam logic [2:0] MODE_NONE      = 3'd0;
	localparam logic [2:0] MODE_SNOW      = 3'd1;
	localparam logic [2:0] MODE_RAIN      = 3'd2;
	localparam logic [2:0] MODE_SANDSTORM = 3'd3;
	localparam logic [2:0] MODE_SNOWSTORM = 3'd4;
	localparam logic [2:0] MODE_FLAMES    = 3'd5;

	// Configuration register indexes
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;
	localparam logic [CFG_IDX_W-1:0] REG_WEATHER_MODE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SAND_BASE    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SNOW_BASE    = 2'd2;

	// Sprite shapes and palettes
	localparam logic [1:0] SHAPE_SMALL  = 2'd0;
	localparam logic [1:0] SHAPE_DROP   = 2'd1;
	localparam logic [1:0] SHAPE_STREAK = 2'd2;
	localparam logic [1:0] SHAPE_BIG    = 2'd3;
	localparam logic PAL_SYSTEM = 1'b0;
	localparam logic PAL_FLAME  = 1'b1;

	// Snow parallax layers
	localparam logic [1:0] KIND_FAR  = 2'd0;
	localparam logic [1:0] KIND_NEAR = 2'd2;

	// Flame row window and tile ramp
	localparam logic [7:0] FLAME_ROW_MIN    = 8'h40;
	localparam logic [7:0] FLAME_ROW_MAX    = 8'hA0;
	localparam logic [4:0] FLAME_TILE_TOP   = 5'd31;
	localparam logic [4:0] FLAME_TILE_FLOOR = 5'd24;

	// Sandstorm x offset
	localparam logic [8:0] SAND_X_OFFSET = 9'h010;

	// Command queue depth
	localparam int QUEUE_DEPTH = 2;

	typedef struct packed {
		logic              is_load;
		logic [5:0]        slot;
		logic signed [15:0] pos_x;
		logic signed [15:0] pos_y;
		logic signed [15:0] speed_x;
		logic signed [15:0] speed_y;
		logic [7:0]        glyph;
		logic [1:0]        depth_kind;
		logic [2:0]        mode;
		logic              frame_odd;
		logic [7:0]        org_far;
		logic [7:0]        org_mid;
		logic [7:0]        org_near;
		logic [7:0]        cam_y;
	} spe_cmd_t;

	typedef struct packed {
		logic [8:0] screen_x;
		logic [7:0] screen_y;
		logic [1:0] shape;
		logic [9:0] tile;
		logic       palette;
	} spe_sprite_t;

endpackage

// ===== hw/rtl/spe_ram.sv =====
// spe_ram: generic single write port, single read port RAM with registered read.
// No dependencies.
module spe_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== hw/rtl/spe_front.sv =====
// spe_front: configuration registers, item acceptance and classification.
// Builds command words for the queue. Depends on spe_pkg.
module spe_front #(
	parameter int PARTICLE_COUNT = 64
) (
	input  logic                             clk,
	input  logic                             arst_n,
	// configuration write channel
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [spe_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [spe_pkg::CFG_DATA_W-1:0]   cfg_data,
	// item channel
	input  logic                             start,
	output logic                             busy,
	input  logic                             op,
	input  logic [5:0]                       slot,
	input  logic signed [15:0]               pos_x,
	input  logic signed [15:0]               pos_y,
	input  logic signed [15:0]               speed_x,
	input  logic signed [15:0]               speed_y,
	input  logic [7:0]                       glyph,
	input  logic [1:0]                       depth_kind,
	input  logic [11:0]                      camera_x,
	input  logic [11:0]                      camera_y,
	input  logic                             frame_odd,
	input  logic                             sprite_room,
	// queue side
	input  logic                             q_full,
	output logic                             push,
	output spe_pkg::spe_cmd_t                cmd,
	// live tile bases for the back end
	output logic [9:0]                       sand_base,
	output logic [9:0]                       snow_base
);
	import spe_pkg::*;

	logic [2:0]  mode_q;
	logic [9:0]  sand_base_q;
	logic [9:0]  snow_base_q;
	logic        accept;
	logic        load_ok;
	logic        tick_ok;
	logic [13:0] cam_x3;
	logic [14:0] cam_x5;

	// config writes are always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_NONE;
			sand_base_q <= '0;
			snow_base_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WEATHER_MODE: mode_q      <= cfg_data[2:0];
				REG_SAND_BASE:    sand_base_q <= cfg_data;
				REG_SNOW_BASE:    snow_base_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign sand_base = sand_base_q;
	assign snow_base = snow_base_q;

	// classify: out-of-table loads and idle ticks are dropped here
	assign busy    = q_full;
	assign accept  = start && !busy;
	assign load_ok = (32'(slot) < PARTICLE_COUNT);
	assign tick_ok = sprite_room && (mode_q != MODE_NONE) && (mode_q <= MODE_FLAMES);
	assign push    = accept && ((op == OP_LOAD) ? load_ok : tick_ok);

	// parallax origins: 3/4 and 5/4 of camera x, low byte only
	assign cam_x3 = {1'b0, camera_x, 1'b0} + {2'b00, camera_x};
	assign cam_x5 = {1'b0, camera_x, 2'b00} + {3'b000, camera_x};

	always_comb begin
		cmd.is_load    = (op == OP_LOAD);
		cmd.slot       = slot;
		cmd.pos_x      = pos_x;
		cmd.pos_y      = pos_y;
		cmd.speed_x    = speed_x;
		cmd.speed_y    = speed_y;
		cmd.glyph      = glyph;
		cmd.depth_kind = depth_kind;
		cmd.mode       = mode_q;
		cmd.frame_odd  = frame_odd;
		cmd.org_far    = cam_x3[9:2];
		cmd.org_mid    = camera_x[7:0];
		cmd.org_near   = cam_x5[9:2];
		cmd.cam_y      = camera_y[7:0];
	end

endmodule

// ===== hw/rtl/spe_cmd_queue.sv =====
// spe_cmd_queue: short FIFO of command words between front and back.
// Depends on spe_pkg.
module spe_cmd_queue (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  spe_pkg::spe_cmd_t push_cmd,
	input  logic              pop,
	output logic              full,
	output logic              not_empty,
	output spe_pkg::spe_cmd_t head
);
	import spe_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	spe_cmd_t          entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign full      = (count_q == CNT_W'(QUEUE_DEPTH));
	assign not_empty = (count_q != '0);
	assign head      = entry_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

`ifndef ASSERT_OFF
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full) else $error("queue push while full");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> not_empty) else $error("queue pop while empty");
`endif

endmodule

// ===== hw/rtl/spe_back.sv =====
// spe_back: particle table walker. Performs loads, advances particles one entry
// a cycle, projects them and emits sprite words. Depends on spe_pkg, spe_ram.
module spe_back #(
	parameter int PARTICLE_COUNT = 64,
	parameter int PER_FRAME      = 32,
	parameter int FLAME_COUNT    = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cmd_valid,
	input  spe_pkg::spe_cmd_t    cmd,
	output logic                 cmd_pop,
	input  logic [9:0]           sand_base,
	input  logic [9:0]           snow_base,
	output logic                 sprite_valid,
	output spe_pkg::spe_sprite_t sprite,
	output logic                 sprite_last
);
	import spe_pkg::*;

	localparam int IDX_W     = $clog2(PARTICLE_COUNT);
	localparam int MAX_CNT   = (PER_FRAME > FLAME_COUNT) ? PER_FRAME : FLAME_COUNT;
	localparam int CNT_W     = $clog2(MAX_CNT + 1);
	localparam int START_ODD = PER_FRAME % PARTICLE_COUNT;

	// walker state
	logic             active_q;
	logic [IDX_W-1:0] idx_q;
	logic [CNT_W-1:0] cnt_q;
	spe_cmd_t         cmd_q;
	logic [IDX_W-1:0] idx_nxt;
	logic             load_wr;
	logic             tick_go;
	logic [IDX_W-1:0] tick_start;
	logic [CNT_W-1:0] tick_count;

	// compute stage
	logic             s1_valid_q;
	logic             s1_final_q;
	logic [IDX_W-1:0] s1_idx_s1;

	// memories
	logic             mot_we;
	logic [IDX_W-1:0] mot_waddr;
	logic [63:0]      mot_wdata;
	logic [63:0]      mot_rdata;
	logic [9:0]       look_rdata;

	// projection
	logic [15:0]      nx;
	logic [15:0]      ny;
	logic [7:0]       origin;
	logic [7:0]       sx8;
	logic [7:0]       sy8;
	logic [7:0]       flame_row;
	logic [4:0]       flame_ramp;
	logic [4:0]       flame_tile;
	logic             keep;
	spe_sprite_t      new_spr;

	// pending sprite and output word
	logic             pend_valid_q;
	spe_sprite_t      pend_q;
	logic             flush_q;
	logic             out_valid_q;
	spe_sprite_t      out_q;
	logic             out_last_q;

	// take a command only once the previous tick has drained its compute stage
	assign cmd_pop = cmd_valid && !active_q && !s1_valid_q;
	assign load_wr = cmd_pop && cmd.is_load;
	assign tick_go = cmd_pop && !cmd.is_load;

	assign tick_start = (cmd.mode == MODE_FLAMES || !cmd.frame_odd) ? '0 : IDX_W'(START_ODD);
	assign tick_count = (cmd.mode == MODE_FLAMES) ? CNT_W'(FLAME_COUNT) : CNT_W'(PER_FRAME);
	assign idx_nxt    = (idx_q == IDX_W'(PARTICLE_COUNT - 1)) ? '0 : idx_q + 1'b1;

	// read sequencer: one table entry per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			idx_q      <= '0;
			cnt_q      <= '0;
			s1_valid_q <= 1'b0;
			s1_final_q <= 1'b0;
		end else begin
			s1_valid_q <= active_q;
			s1_final_q <= active_q && (cnt_q == CNT_W'(1));
			if (tick_go) begin
				active_q <= 1'b1;
				idx_q    <= tick_start;
				cnt_q    <= tick_count;
			end else if (active_q) begin
				idx_q <= idx_nxt;
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					active_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (tick_go) begin
			cmd_q <= cmd;
		end
		s1_idx_s1 <= idx_q;
	end

	// write port: write-back during a walk, load otherwise
	assign mot_we    = s1_valid_q || load_wr;
	assign mot_waddr = s1_valid_q ? s1_idx_s1 : IDX_W'(cmd.slot);
	assign mot_wdata = s1_valid_q ? {mot_rdata[63:32], ny, nx}
	                              : {cmd.speed_y, cmd.speed_x, cmd.pos_y, cmd.pos_x};

	spe_ram #(.WIDTH(64), .DEPTH(PARTICLE_COUNT)) u_motion_ram (
		.clk   (clk),
		.we    (mot_we),
		.waddr (mot_waddr),
		.wdata (mot_wdata),
		.raddr (idx_q),
		.rdata (mot_rdata)
	);

	spe_ram #(.WIDTH(10), .DEPTH(PARTICLE_COUNT)) u_look_ram (
		.clk   (clk),
		.we    (load_wr),
		.waddr (IDX_W'(cmd.slot)),
		.wdata ({cmd.depth_kind, cmd.glyph}),
		.raddr (idx_q),
		.rdata (look_rdata)
	);

	// advance and project
	assign nx = mot_rdata[15:0] + mot_rdata[47:32];
	assign ny = (cmd_q.mode == MODE_SANDSTORM) ? mot_rdata[31:16]
	                                          : mot_rdata[31:16] + mot_rdata[63:48];

	always_comb begin
		origin = cmd_q.org_mid;
		if (cmd_q.mode == MODE_SNOW) begin
			if (look_rdata[9:8] == KIND_FAR) begin
				origin = cmd_q.org_far;
			end else if (look_rdata[9:8] == KIND_NEAR) begin
				origin = cmd_q.org_near;
			end
		end
	end

	assign sx8 = nx[15:8] - origin;
	assign sy8 = ny[15:8] - cmd_q.cam_y;

	// flame tile ramps down by one every 8 rows, floored
	assign flame_row  = sy8 - FLAME_ROW_MIN;
	assign flame_ramp = FLAME_TILE_TOP - flame_row[7:3];
	assign flame_tile = (flame_ramp < FLAME_TILE_FLOOR) ? FLAME_TILE_FLOOR : flame_ramp;

	always_comb begin
		new_spr.screen_x = {1'b0, sx8};
		new_spr.screen_y = sy8;
		new_spr.shape    = SHAPE_SMALL;
		new_spr.tile     = {2'b00, look_rdata[7:0]};
		new_spr.palette  = PAL_SYSTEM;
		keep             = 1'b1;
		unique case (cmd_q.mode)
			MODE_SNOW: ;
			MODE_RAIN: begin
				new_spr.shape = (look_rdata[7:0] == 8'd0) ? SHAPE_DROP : SHAPE_STREAK;
				new_spr.tile  = '0;
			end
			MODE_SANDSTORM: begin
				new_spr.screen_x = {1'b0, nx[7:0]} - SAND_X_OFFSET;
				new_spr.screen_y = ny[7:0];
				new_spr.shape    = SHAPE_BIG;
				new_spr.tile     = sand_base;
			end
			MODE_SNOWSTORM: begin
				new_spr.shape = SHAPE_BIG;
				new_spr.tile  = snow_base + {look_rdata[7:0], 2'b00};
			end
			MODE_FLAMES: begin
				new_spr.tile    = {5'b00000, flame_tile};
				new_spr.palette = PAL_FLAME;
				keep            = (sy8 >= FLAME_ROW_MIN) && (sy8 <= FLAME_ROW_MAX);
			end
			default: keep = 1'b0;
		endcase
	end

	// one sprite held back so the final one of a tick can carry last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			pend_q       <= '0;
			flush_q      <= 1'b0;
			out_valid_q  <= 1'b0;
			out_q        <= '0;
			out_last_q   <= 1'b0;
		end else begin
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
			if (flush_q) begin
				out_valid_q  <= 1'b1;
				out_q        <= pend_q;
				out_last_q   <= 1'b1;
				pend_valid_q <= 1'b0;
				flush_q      <= 1'b0;
			end else if (s1_valid_q) begin
				if (keep) begin
					if (pend_valid_q) begin
						out_valid_q <= 1'b1;
						out_q       <= pend_q;
					end
					pend_q       <= new_spr;
					pend_valid_q <= 1'b1;
					flush_q      <= s1_final_q;
				end else if (s1_final_q && pend_valid_q) begin
					out_valid_q  <= 1'b1;
					out_q        <= pend_q;
					out_last_q   <= 1'b1;
					pend_valid_q <= 1'b0;
				end
			end
		end
	end

	assign sprite_valid = out_valid_q;
	assign sprite       = out_q;
	assign sprite_last  = out_last_q;

`ifndef ASSERT_OFF
	a_flush_has_word: assert property (@(posedge clk) disable iff (!arst_n)
		flush_q |-> pend_valid_q) else $error("flush without pending sprite");
	a_last_then_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(sprite_valid && sprite_last) |=> !sprite_valid) else $error("sprite right after last");
	a_walk_count: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> (cnt_q != '0)) else $error("walk active with zero count");
`endif

endmodule

// ===== hw/rtl/sprite_particle_engine.sv =====
// Tick: the command goes through the queue, then the walker reads one table entry per cycle
// for count entries (count = PER_FRAME, or FLAME_COUNT); each kept sprite passes the pending
// and output registers, and the last kept one carries last. The walker is held until the read
// and write-back stages drain before the next command. A load writes the table as it is popped.
// Two commands queue; busy when full.
// Reset clears control and configuration; the particle table is undefined until loaded.
// Sprites cannot be stalled: each is valid for exactly one cycle.
module sprite_particle_engine #(
	parameter int PARTICLE_COUNT = 64,
	parameter int PER_FRAME      = 32,
	parameter int FLAME_COUNT    = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [spe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [spe_pkg::CFG_DATA_W-1:0] cfg_data,
	// items
	input  logic                           start,
	output logic                           busy,
	input  logic                           op,
	input  logic [5:0]                     slot,
	input  logic signed [15:0]             pos_x,
	input  logic signed [15:0]             pos_y,
	input  logic signed [15:0]             speed_x,
	input  logic signed [15:0]             speed_y,
	input  logic [7:0]                     glyph,
	input  logic [1:0]                     depth_kind,
	input  logic [11:0]                    camera_x,
	input  logic [11:0]                    camera_y,
	input  logic                           frame_odd,
	input  logic                           sprite_room,
	// sprites
	output logic                           sprite_valid,
	output logic [8:0]                     screen_x,
	output logic [7:0]                     screen_y,
	output logic [1:0]                     sprite_shape,
	output logic [9:0]                     tile_index,
	output logic                           palette_select,
	output logic                           last
);
	import spe_pkg::*;

	logic        q_full;
	logic        q_not_empty;
	logic        q_push;
	logic        q_pop;
	spe_cmd_t    push_cmd;
	spe_cmd_t    head_cmd;
	logic [9:0]  sand_base;
	logic [9:0]  snow_base;
	spe_sprite_t spr;

	spe_front #(.PARTICLE_COUNT(PARTICLE_COUNT)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.start       (start),
		.busy        (busy),
		.op          (op),
		.slot        (slot),
		.pos_x       (pos_x),
		.pos_y       (pos_y),
		.speed_x     (speed_x),
		.speed_y     (speed_y),
		.glyph       (glyph),
		.depth_kind  (depth_kind),
		.camera_x    (camera_x),
		.camera_y    (camera_y),
		.frame_odd   (frame_odd),
		.sprite_room (sprite_room),
		.q_full      (q_full),
		.push        (q_push),
		.cmd         (push_cmd),
		.sand_base   (sand_base),
		.snow_base   (snow_base)
	);

	spe_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_cmd  (push_cmd),
		.pop       (q_pop),
		.full      (q_full),
		.not_empty (q_not_empty),
		.head      (head_cmd)
	);

	spe_back #(
		.PARTICLE_COUNT (PARTICLE_COUNT),
		.PER_FRAME      (PER_FRAME),
		.FLAME_COUNT    (FLAME_COUNT)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (q_not_empty),
		.cmd          (head_cmd),
		.cmd_pop      (q_pop),
		.sand_base    (sand_base),
		.snow_base    (snow_base),
		.sprite_valid (sprite_valid),
		.sprite       (spr),
		.sprite_last  (last)
	);

	assign screen_x       = spr.screen_x;
	assign screen_y       = spr.screen_y;
	assign sprite_shape   = spr.shape;
	assign tile_index     = spr.tile;
	assign palette_select = spr.palette;

endmodule

// ===== sim/spe_checker.sv =====
`timescale 1ns / 1ps
// spe_checker: watches the item, register and sprite channels of the sprite particle engine.
// It keeps a shadow particle table, predicts every sprite word and compares it on arrival.
// Depends on spe_pkg for mode, register, shape, palette and flame ramp codes.
module spe_checker #(
	parameter int PARTICLE_COUNT = 64,
	parameter int PER_FRAME      = 32,
	parameter int FLAME_COUNT    = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [spe_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [spe_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           start,
	input  logic                           busy,
	input  logic                           op,
	input  logic [5:0]                     slot,
	input  logic signed [15:0]             pos_x,
	input  logic signed [15:0]             pos_y,
	input  logic signed [15:0]             speed_x,
	input  logic signed [15:0]             speed_y,
	input  logic [7:0]                     glyph,
	input  logic [1:0]                     depth_kind,
	input  logic [11:0]                    camera_x,
	input  logic [11:0]                    camera_y,
	input  logic                           frame_odd,
	input  logic                           sprite_room,
	input  logic                           sprite_valid,
	input  logic [8:0]                     screen_x,
	input  logic [7:0]                     screen_y,
	input  logic [1:0]                     sprite_shape,
	input  logic [9:0]                     tile_index,
	input  logic                           palette_select,
	input  logic                           last,
	output int                             fail_count,
	output int                             pending_count
);
	import spe_pkg::*;

	localparam int REPORT_LIMIT = 10;
	localparam int MAX_WORDS    = (PER_FRAME > FLAME_COUNT) ? PER_FRAME : FLAME_COUNT;
	// snow parallax: far layer at 12/16, near layer at 20/16 of the camera x
	localparam int FAR_SCALE    = 12;
	localparam int NEAR_SCALE   = 20;

	typedef struct packed {
		logic [8:0] screen_x;
		logic [7:0] screen_y;
		logic [1:0] shape;
		logic [9:0] tile;
		logic       palette;
		logic       last;
	} sprite_word_t;

	// Shadow particle table and registers
	logic [15:0] part_x     [PARTICLE_COUNT];
	logic [15:0] part_y     [PARTICLE_COUNT];
	logic [15:0] part_vx    [PARTICLE_COUNT];
	logic [15:0] part_vy    [PARTICLE_COUNT];
	logic [7:0]  part_glyph [PARTICLE_COUNT];
	logic [1:0]  part_kind  [PARTICLE_COUNT];
	logic [2:0]  weather;
	logic [9:0]  sand_base;
	logic [9:0]  snow_base;

	sprite_word_t sprites_due[$];
	sprite_word_t seen;

	// Advance one slice of the table and queue the sprites it shows
	task automatic advance_frame(input logic [11:0] camx, input logic [11:0] camy,
			input logic odd);
		int first;
		int span;
		int e;
		int n;
		int org;
		int ramp;
		logic [15:0] nx;
		logic [15:0] ny;
		logic [7:0] row;
		sprite_word_t frame_words [MAX_WORDS];
		sprite_word_t w;
		n = 0;
		if (weather == MODE_FLAMES) begin
			first = 0;
			span = FLAME_COUNT;
		end else begin
			first = odd ? PER_FRAME : 0;
			span = PER_FRAME;
		end
		for (int i = 0; i < span; i++) begin
			e = (first + i) % PARTICLE_COUNT;
			nx = part_x[e] + part_vx[e];
			ny = (weather == MODE_SANDSTORM) ? part_y[e] : part_y[e] + part_vy[e];
			part_x[e] = nx;
			part_y[e] = ny;
			row = ny[15:8] - camy[7:0];
			w = '0;
			w.screen_x = {1'b0, nx[15:8] - camx[7:0]};
			w.screen_y = row;
			w.palette = PAL_SYSTEM;
			case (weather)
				MODE_SNOW: begin
					if (part_kind[e] == KIND_FAR)
						org = int'(camx) * FAR_SCALE / 16;
					else if (part_kind[e] == KIND_NEAR)
						org = int'(camx) * NEAR_SCALE / 16;
					else
						org = int'(camx);
					w.screen_x = {1'b0, nx[15:8] - org[7:0]};
					w.shape = SHAPE_SMALL;
					w.tile = {2'b00, part_glyph[e]};
				end
				MODE_RAIN: begin
					w.shape = (part_glyph[e] == 8'h00) ? SHAPE_DROP : SHAPE_STREAK;
					w.tile = '0;
				end
				MODE_SANDSTORM: begin
					// x from the fraction byte, y not projected
					w.screen_x = {1'b0, nx[7:0]} - SAND_X_OFFSET;
					w.screen_y = ny[7:0];
					w.shape = SHAPE_BIG;
					w.tile = sand_base;
				end
				MODE_SNOWSTORM: begin
					w.shape = SHAPE_BIG;
					w.tile = snow_base + {part_glyph[e], 2'b00};
				end
				default: begin
					// flames: rows outside the window are moved but not drawn
					if (row < FLAME_ROW_MIN || row > FLAME_ROW_MAX)
						continue;
					ramp = int'(FLAME_TILE_TOP) - (int'(row) - int'(FLAME_ROW_MIN)) / 8;
					if (ramp < int'(FLAME_TILE_FLOOR))
						ramp = int'(FLAME_TILE_FLOOR);
					w.shape = SHAPE_SMALL;
					w.tile = ramp[9:0];
					w.palette = PAL_FLAME;
				end
			endcase
			frame_words[n] = w;
			n++;
		end
		for (int k = 0; k < n; k++) begin
			w = frame_words[k];
			w.last = (k == n - 1);
			sprites_due.push_back(w);
		end
	endtask

	// Compare one sprite word with the oldest prediction
	task automatic check_sprite(input sprite_word_t got);
		sprite_word_t want;
		if (sprites_due.size() == 0) begin
			fail_count++;
			if (fail_count <= REPORT_LIMIT)
				$display("%0t: unexpected sprite x=%0d y=%0d shape=%0d tile=%0d pal=%0d last=%0d",
					$time, got.screen_x, got.screen_y, got.shape, got.tile, got.palette,
					got.last);
		end else begin
			want = sprites_due.pop_front();
			if (got !== want) begin
				fail_count++;
				if (fail_count <= REPORT_LIMIT) begin
					$display("%0t: sprite mismatch, expected x=%0d y=%0d shape=%0d tile=%0d pal=%0d last=%0d",
						$time, want.screen_x, want.screen_y, want.shape, want.tile,
						want.palette, want.last);
					$display("%0t: sprite mismatch, got x=%0d y=%0d shape=%0d tile=%0d pal=%0d last=%0d",
						$time, got.screen_x, got.screen_y, got.shape, got.tile,
						got.palette, got.last);
				end
			end
		end
	endtask

	initial begin
		fail_count = 0;
		pending_count = 0;
	end

	// Sample all channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weather = MODE_NONE;
			sand_base = '0;
			snow_base = '0;
			sprites_due.delete();
			pending_count = 0;
		end else begin
			if (sprite_valid) begin
				seen.screen_x = screen_x;
				seen.screen_y = screen_y;
				seen.shape = sprite_shape;
				seen.tile = tile_index;
				seen.palette = palette_select;
				seen.last = last;
				check_sprite(seen);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WEATHER_MODE: weather = cfg_data[2:0];
					REG_SAND_BASE:    sand_base = cfg_data;
					REG_SNOW_BASE:    snow_base = cfg_data;
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (op == OP_LOAD) begin
					if (int'(slot) < PARTICLE_COUNT) begin
						part_x[slot] = pos_x;
						part_y[slot] = pos_y;
						part_vx[slot] = speed_x;
						part_vy[slot] = speed_y;
						part_glyph[slot] = glyph;
						part_kind[slot] = depth_kind;
					end
				end else if (sprite_room && weather != MODE_NONE && weather <= MODE_FLAMES) begin
					advance_frame(camera_x, camera_y, frame_odd);
				end
			end
			pending_count = sprites_due.size();
		end
	end

endmodule

// ===== sim/sprite_particle_engine_test.sv =====
`timescale 1ns / 1ps
// sprite_particle_engine_test: drives particle loads, frame ticks and register writes
// into the sprite particle engine and prints the verdict; checking is done by spe_checker.
// Depends on spe_pkg, sprite_particle_engine and spe_checker.
module sprite_particle_engine_test;
	import spe_pkg::*;

	localparam int PARTICLE_COUNT = 64;
	localparam int PER_FRAME      = 32;
	localparam int FLAME_COUNT    = 16;
	// a queue full of ticks that draw nothing may still be walking
	localparam int QUIET_CYCLES   = (QUEUE_DEPTH + 1) * (PER_FRAME + 6);
	localparam int CYCLE_LIMIT    = 200000;
	localparam int PHASES         = 10;
	localparam int PHASE_WORDS    = 30;
	localparam int BASE_MAX       = (1 << CFG_DATA_W) - 1;
	localparam logic [2:0] MODE_UNUSED = 3'd7;

	typedef struct packed {
		logic        op;
		logic [5:0]  slot;
		logic [15:0] pos_x;
		logic [15:0] pos_y;
		logic [15:0] speed_x;
		logic [15:0] speed_y;
		logic [7:0]  glyph;
		logic [1:0]  depth_kind;
		logic [11:0] camera_x;
		logic [11:0] camera_y;
		logic        frame_odd;
		logic        sprite_room;
	} item_word_t;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic                  start;
	logic                  busy;
	logic                  op;
	logic [5:0]            slot;
	logic signed [15:0]    pos_x;
	logic signed [15:0]    pos_y;
	logic signed [15:0]    speed_x;
	logic signed [15:0]    speed_y;
	logic [7:0]            glyph;
	logic [1:0]            depth_kind;
	logic [11:0]           camera_x;
	logic [11:0]           camera_y;
	logic                  frame_odd;
	logic                  sprite_room;
	logic                  sprite_valid;
	logic [8:0]            screen_x;
	logic [7:0]            screen_y;
	logic [1:0]            sprite_shape;
	logic [9:0]            tile_index;
	logic                  palette_select;
	logic                  last;
	int                    fail_count;
	int                    pending_count;
	int                    cycle_count = 0;
	bit                    gaps_on;

	sprite_particle_engine #(
		.PARTICLE_COUNT(PARTICLE_COUNT),
		.PER_FRAME(PER_FRAME),
		.FLAME_COUNT(FLAME_COUNT)
	) i_dut (.*);

	spe_checker #(
		.PARTICLE_COUNT(PARTICLE_COUNT),
		.PER_FRAME(PER_FRAME),
		.FLAME_COUNT(FLAME_COUNT)
	) i_checker (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
	end

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	// Random word; glyph zero is favored so rain drops show up
	function automatic item_word_t random_word(input logic is_tick);
		item_word_t w;
		w.op = is_tick ? OP_TICK : OP_LOAD;
		w.slot = 6'($urandom);
		w.pos_x = 16'($urandom);
		w.pos_y = 16'($urandom);
		w.speed_x = 16'($urandom);
		w.speed_y = 16'($urandom);
		w.glyph = ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom);
		w.depth_kind = 2'($urandom);
		w.camera_x = 12'($urandom);
		w.camera_y = 12'($urandom);
		w.frame_odd = 1'($urandom);
		w.sprite_room = ($urandom_range(0, 9) != 0);
		return w;
	endfunction

	// Present one word at the falling edge and hold it until accepted
	task automatic send_word(input item_word_t w);
		while (gaps_on && $urandom_range(0, 99) < 15) begin
			start = 1'b0;
			@(negedge clk);
		end
		op = w.op;
		slot = w.slot;
		pos_x = w.pos_x;
		pos_y = w.pos_y;
		speed_x = w.speed_x;
		speed_y = w.speed_y;
		glyph = w.glyph;
		depth_kind = w.depth_kind;
		camera_x = w.camera_x;
		camera_y = w.camera_y;
		frame_odd = w.frame_odd;
		sprite_room = w.sprite_room;
		start = 1'b1;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// Drain: no sprites left to come and the walker has gone quiet
	task automatic settle();
		start = 1'b0;
		while (pending_count != 0)
			@(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
		cfg_index = idx;
		cfg_data = value[CFG_DATA_W-1:0];
		cfg_valid = 1'b1;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	initial begin
		item_word_t w;
		logic [2:0] phase_mode;
		logic [15:0] flame_rows [6];
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_WEATHER_MODE;
		cfg_data = '0;
		start = 1'b0;
		op = OP_LOAD;
		slot = '0;
		pos_x = '0;
		pos_y = '0;
		speed_x = '0;
		speed_y = '0;
		glyph = '0;
		depth_kind = '0;
		camera_x = '0;
		camera_y = '0;
		frame_odd = 1'b0;
		sprite_room = 1'b0;
		gaps_on = 1'b1;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Fill the whole table so that no tick reads an unwritten entry
		for (int s = 0; s < PARTICLE_COUNT; s++) begin
			w = random_word(1'b0);
			w.slot = s[5:0];
			send_word(w);
		end

		// Directed: position and speed extremes with wrap, every depth kind
		w = random_word(1'b0);
		w.slot = 6'd0;
		w.pos_x = 16'h7FFF;
		w.speed_x = 16'h7FFF;
		w.pos_y = 16'h8000;
		w.speed_y = 16'h8000;
		w.glyph = 8'hFF;
		w.depth_kind = 2'd3;
		send_word(w);
		w = random_word(1'b0);
		w.slot = 6'd63;
		w.pos_x = 16'h0000;
		w.pos_y = 16'h0000;
		w.speed_x = 16'h0000;
		w.speed_y = 16'h0000;
		w.glyph = 8'h00;
		w.depth_kind = KIND_FAR;
		send_word(w);
		w = random_word(1'b0);
		w.slot = 6'd34;
		w.pos_x = 16'hFFFF;
		w.pos_y = 16'hFFFF;
		w.speed_x = 16'hFFFF;
		w.speed_y = 16'hFFFF;
		w.glyph = 8'h00;
		w.depth_kind = KIND_NEAR;
		send_word(w);
		w = random_word(1'b0);
		w.slot = 6'd1;
		w.glyph = 8'h01;
		w.depth_kind = 2'd1;
		send_word(w);

		// Flame rows on and around the window edges and the tile floor
		flame_rows = '{16'h3F00, 16'h4000, 16'h4800, 16'h8000, 16'hA000, 16'hA100};
		for (int k = 0; k < 6; k++) begin
			w = random_word(1'b0);
			w.slot = 6'(k + 3);
			w.pos_y = flame_rows[k];
			w.speed_y = 16'h0000;
			send_word(w);
		end

		// Tick with no weather draws nothing
		w = random_word(1'b1);
		w.sprite_room = 1'b1;
		send_word(w);

		// Snow: both halves, camera extremes, and a frame without sprite room
		settle();
		write_reg(REG_WEATHER_MODE, MODE_SNOW);
		w = random_word(1'b1);
		w.frame_odd = 1'b0;
		w.camera_x = 12'hFFF;
		w.camera_y = 12'hFFF;
		w.sprite_room = 1'b1;
		send_word(w);
		w.frame_odd = 1'b1;
		w.camera_x = 12'h000;
		w.camera_y = 12'h000;
		send_word(w);
		w = random_word(1'b1);
		w.sprite_room = 1'b0;
		send_word(w);

		// Rain: drops and streaks in both halves
		settle();
		write_reg(REG_WEATHER_MODE, MODE_RAIN);
		w = random_word(1'b1);
		w.sprite_room = 1'b1;
		w.frame_odd = 1'b1;
		send_word(w);
		w.frame_odd = 1'b0;
		send_word(w);

		// Sandstorm and snowstorm with the top tile base
		settle();
		write_reg(REG_WEATHER_MODE, MODE_SANDSTORM);
		write_reg(REG_SAND_BASE, BASE_MAX);
		w = random_word(1'b1);
		w.sprite_room = 1'b1;
		send_word(w);
		settle();
		write_reg(REG_WEATHER_MODE, MODE_SNOWSTORM);
		write_reg(REG_SNOW_BASE, BASE_MAX);
		w = random_word(1'b1);
		w.sprite_room = 1'b1;
		w.frame_odd = 1'b0;
		send_word(w);

		// Flames against the row window, then a random camera
		settle();
		write_reg(REG_WEATHER_MODE, MODE_FLAMES);
		w = random_word(1'b1);
		w.sprite_room = 1'b1;
		w.camera_y = 12'h000;
		send_word(w);
		w = random_word(1'b1);
		w.sprite_room = 1'b1;
		send_word(w);

		// Undefined mode code draws nothing
		settle();
		write_reg(REG_WEATHER_MODE, MODE_UNUSED);
		w = random_word(1'b1);
		w.sprite_room = 1'b1;
		send_word(w);

		// Random phases, each with its own mode and tile bases
		for (int p = 0; p < PHASES; p++) begin
			settle();
			case (p % 5)
				0:       phase_mode = MODE_SNOW;
				1:       phase_mode = MODE_RAIN;
				2:       phase_mode = MODE_SANDSTORM;
				3:       phase_mode = MODE_SNOWSTORM;
				default: phase_mode = MODE_FLAMES;
			endcase
			write_reg(REG_WEATHER_MODE, phase_mode);
			write_reg(REG_SAND_BASE, (p % 3 == 0) ? 0 :
				(p % 3 == 1) ? BASE_MAX : $urandom_range(0, BASE_MAX));
			write_reg(REG_SNOW_BASE, (p % 3 == 1) ? 0 :
				(p % 3 == 2) ? BASE_MAX : $urandom_range(0, BASE_MAX));
			// two phases run back to back with no gaps
			gaps_on = (p != 4 && p != 5);
			for (int n = 0; n < PHASE_WORDS; n++)
				send_word(random_word($urandom_range(0, 99) < 40));
		end

		settle();
		if (fail_count == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
